// ===== design/package_merge_depth_counter_assert.svh =====
`ifndef PACKAGE_MERGE_DEPTH_COUNTER_ASSERT_SVH
`define PACKAGE_MERGE_DEPTH_COUNTER_ASSERT_SVH

// condition holds at every edge outside reset
`define PMDC_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define PMDC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/pmdc_pkg.sv =====
package pmdc_pkg;

  localparam int MAX_SYMBOLS = 131072;
  localparam int MAX_LEVELS  = 32;

  localparam int SYM_W = $clog2(MAX_SYMBOLS);
  localparam int CNT_W = 18;
  localparam int VAL_W = 32;
  localparam int LEN_W = 6;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_NODE = 2'd1,
    CMD_READ = 2'd2
  } cmd_t;

  typedef struct packed {
    cmd_t             command;
    logic [SYM_W-1:0] symbol_index;
    logic [VAL_W-1:0] item_value;
    logic             is_package;
    logic             last_in_level;
  } in_item_t;

  typedef struct packed {
    logic [SYM_W-1:0] depth_symbol;
    logic [LEN_W-1:0] code_length;
  } out_item_t;

  typedef struct packed {
    logic             valid;
    cmd_t             command;
    logic [SYM_W-1:0] addr;
    logic [VAL_W-1:0] value;
    logic             in_range;
  } stage_t;

endpackage

// ===== design/package_merge_depth_counter.sv =====
// read path: a read result passes the s1 stage register and then the output buffer
// register before it is valid on the output
// throughput: one transaction per cycle, set by the single read-modify-write stage
// around the frequency and depth memories; input stalls when the two-entry output buffer will be full
// reset: clears control state, leaf counter and symbol count; memories are not
// cleared and need no clearing pass, so input is taken right after reset
module package_merge_depth_counter (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  pmdc_pkg::in_item_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output pmdc_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [pmdc_pkg::CNT_W-1:0] cfg_data
);
  import pmdc_pkg::*;

  localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};
  localparam logic [CNT_W-1:0] LIMIT_MAX = CNT_W'(MAX_SYMBOLS);
  localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_LEVELS);

  logic [VAL_W-1:0] freq_mem [MAX_SYMBOLS];
  logic [LEN_W-1:0] depth_mem [MAX_SYMBOLS];

  logic [CNT_W-1:0] symbol_count;
  logic [CNT_W-1:0] leaf_counter;
  logic [CNT_W-1:0] leaf_counter_next;
  logic [CNT_W-1:0] cnt_inc;
  logic [CNT_W-1:0] cnt_dec;
  logic [CNT_W-1:0] limit;
  logic             node_in_range;
  logic [SYM_W-1:0] rd_addr;
  logic             in_acc;

  stage_t           s1;
  stage_t           s1_next;
  logic [VAL_W-1:0] freq_rd;
  logic [LEN_W-1:0] depth_rd;
  logic             fwd_freq;
  logic [VAL_W-1:0] fwd_freq_data;
  logic             fwd_depth;
  logic [LEN_W-1:0] fwd_depth_data;
  logic [VAL_W-1:0] freq_eff;
  logic [LEN_W-1:0] depth_eff;
  logic             freq_we;
  logic             node_hit;
  logic             depth_we;
  logic [LEN_W-1:0] depth_wdata;

  logic [1:0]       occ;
  logic [1:0]       occ_next;
  out_item_t        q0;
  out_item_t        q1;
  out_item_t        push_item;
  logic             push;
  logic             pop;
  logic [2:0]       pending;

  // input side: leaf numbering and read address
  always_comb begin
    in_acc   = in_valid && !in_stall;
    cnt_inc  = (leaf_counter == CNT_MAX) ? leaf_counter : leaf_counter + CNT_W'(1);
    cnt_dec  = cnt_inc - CNT_W'(1);
    limit    = (symbol_count > LIMIT_MAX) ? LIMIT_MAX : symbol_count;
    node_in_range = (cnt_inc <= limit);
    rd_addr  = (in_data.command == CMD_NODE) ? cnt_dec[SYM_W-1:0] : in_data.symbol_index;

    leaf_counter_next = leaf_counter;
    if (in_data.command == CMD_NODE) begin
      if (!in_data.is_package) begin
        leaf_counter_next = cnt_inc;
      end
      if (in_data.last_in_level) begin
        leaf_counter_next = '0;
      end
    end

    s1_next.valid    = in_acc;
    s1_next.command  = in_data.command;
    s1_next.addr     = rd_addr;
    s1_next.value    = in_data.item_value;
    s1_next.in_range = !in_data.is_package && node_in_range;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_count <= '0;
      leaf_counter <= '0;
    end else begin
      if (cfg_we) begin
        symbol_count <= cfg_data;
      end
      if (in_acc) begin
        leaf_counter <= leaf_counter_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else begin
      s1.valid <= s1_next.valid;
    end
    s1.command  <= s1_next.command;
    s1.addr     <= s1_next.addr;
    s1.value    <= s1_next.value;
    s1.in_range <= s1_next.in_range;
    fwd_freq       <= freq_we && (s1.addr == rd_addr);
    fwd_freq_data  <= s1.value;
    fwd_depth      <= depth_we && (s1.addr == rd_addr);
    fwd_depth_data <= depth_wdata;
  end

  // frequency and depth memories
  always_ff @(posedge clk) begin
    if (freq_we) begin
      freq_mem[s1.addr] <= s1.value;
    end
    freq_rd <= freq_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (depth_we) begin
      depth_mem[s1.addr] <= depth_wdata;
    end
    depth_rd <= depth_mem[rd_addr];
  end

  // modify and write back
  always_comb begin
    freq_eff  = fwd_freq ? fwd_freq_data : freq_rd;
    depth_eff = fwd_depth ? fwd_depth_data : depth_rd;
    freq_we   = 1'b0;
    node_hit  = 1'b0;
    push      = 1'b0;
    depth_wdata = '0;
    if (s1.valid) begin
      case (s1.command)
        CMD_LOAD: freq_we = 1'b1;
        CMD_NODE: node_hit = s1.in_range && (freq_eff == s1.value);
        CMD_READ: push = 1'b1;
        default: ;
      endcase
    end
    if (node_hit) begin
      depth_wdata = (depth_eff < LEN_MAX) ? depth_eff + LEN_W'(1) : depth_eff;
    end
    depth_we = freq_we || node_hit;
    push_item.depth_symbol = s1.addr;
    push_item.code_length  = depth_eff;
  end

  // two-entry output buffer
  always_comb begin
    out_valid = (occ != 2'd0);
    out_data  = q0;
    pop       = out_valid && !out_stall;
    occ_next  = occ + {1'b0, push} - {1'b0, pop};
    pending   = {1'b0, occ} + {2'b0, push} - {2'b0, pop};
    in_stall  = (pending >= 3'd2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else begin
      occ <= occ_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && (occ == 2'd2)) begin
      q0 <= q1;
    end
    if (push) begin
      if ((occ - {1'b0, pop}) == 2'd0) begin
        q0 <= push_item;
      end else begin
        q1 <= push_item;
      end
    end
  end

  `include "package_merge_depth_counter_assert.svh"

  `PMDC_ASSERT_ALWAYS(a_buffer_room,
    ({1'b0, occ} + {2'b0, s1.valid && (s1.command == CMD_READ)}) <= 3'd2,
    "output buffer overrun")
  `PMDC_ASSERT_NEXT(a_load_writes, in_acc && (in_data.command == CMD_LOAD),
    depth_we && freq_we, "load transaction not written back")
  `PMDC_ASSERT_NEXT(a_level_end,
    in_acc && (in_data.command == CMD_NODE) && in_data.last_in_level,
    leaf_counter == '0, "leaf counter not cleared at level end")
  `PMDC_ASSERT_NEXT(a_read_result, in_acc && (in_data.command == CMD_READ),
    push && (push_item.depth_symbol == $past(in_data.symbol_index)),
    "read transaction lost")

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import pmdc_pkg::*;

  localparam cmd_t CMD_UNUSED = cmd_t'(2'b11);
  localparam int SEGMENT_ITEMS = 240;

  typedef enum {IDLE_NONE, IDLE_SEND, IDLE_STALL, IDLE_BOTH} idle_mode_t;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t res;
  } row_t;

  logic             clk;
  logic             rst       = 1'b1;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  in_item_t         in_data   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_item_t        out_data;
  logic             cfg_we    = 1'b0;
  logic [CNT_W-1:0] cfg_data  = '0;

  // depth tracking state
  logic [VAL_W-1:0] sym_freq [int];
  logic [LEN_W-1:0] sym_depth [int];
  logic [CNT_W-1:0] leaf_cnt  = '0;
  int               sym_limit = 0;

  out_item_t pending_lengths [$];
  int        send_idle_pct = 0;
  int        stall_pct     = 0;
  int        sent          = 0;
  int        checked       = 0;
  int        mismatches    = 0;

  row_t directed [23] = '{
    '{'{CMD_LOAD, 17'd0, 32'hFFFF_FFFF, 1'b0, 1'b0}, 1'b0, '0},
    '{'{CMD_LOAD, 17'd1, 32'h0000_0000, 1'b1, 1'b1}, 1'b0, '0},
    '{'{CMD_LOAD, 17'd2, 32'h0000_5A5A, 1'b0, 1'b0}, 1'b0, '0},
    '{'{CMD_LOAD, 17'd131071, 32'h1234_5678, 1'b0, 1'b0}, 1'b0, '0},
    '{'{CMD_READ, 17'd0, 32'h0000_0000, 1'b0, 1'b0}, 1'b1, '{17'd0, 6'd0}},
    '{'{CMD_READ, 17'd131071, 32'hFFFF_FFFF, 1'b1, 1'b0}, 1'b1, '{17'd131071, 6'd0}},
    '{'{CMD_NODE, 17'd0, 32'hFFFF_FFFF, 1'b0, 1'b0}, 1'b0, '0},
    '{'{CMD_NODE, 17'd0, 32'hFFFF_FFFF, 1'b1, 1'b0}, 1'b0, '0},
    '{'{CMD_NODE, 17'd0, 32'h0000_0000, 1'b0, 1'b0}, 1'b0, '0},
    '{'{CMD_NODE, 17'd0, 32'h0000_0001, 1'b0, 1'b0}, 1'b0, '0},
    '{'{CMD_NODE, 17'd0, 32'h0000_0000, 1'b0, 1'b1}, 1'b0, '0},
    '{'{CMD_NODE, 17'd0, 32'h0000_0000, 1'b1, 1'b1}, 1'b0, '0},
    '{'{CMD_NODE, 17'd0, 32'hFFFF_FFFF, 1'b0, 1'b1}, 1'b0, '0},
    '{'{CMD_READ, 17'd0, 32'h0000_0000, 1'b0, 1'b0}, 1'b0, '0},
    '{'{CMD_READ, 17'd1, 32'h0000_0000, 1'b0, 1'b0}, 1'b0, '0},
    '{'{CMD_READ, 17'd2, 32'h0000_0000, 1'b0, 1'b0}, 1'b0, '0},
    '{'{CMD_NODE, 17'd0, 32'h0000_0000, 1'b0, 1'b0}, 1'b0, '0},
    '{'{CMD_UNUSED, 17'h1FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1}, 1'b0, '0},
    '{'{CMD_READ, 17'd1, 32'h0000_0000, 1'b0, 1'b1}, 1'b0, '0},
    '{'{CMD_NODE, 17'd0, 32'h0000_0000, 1'b0, 1'b1}, 1'b0, '0},
    '{'{CMD_READ, 17'd1, 32'h0000_0000, 1'b0, 1'b0}, 1'b0, '0},
    '{'{CMD_LOAD, 17'd0, 32'hFFFF_FFFF, 1'b1, 1'b1}, 1'b0, '0},
    '{'{CMD_READ, 17'd0, 32'h0000_0000, 1'b0, 1'b0}, 1'b1, '{17'd0, 6'd0}}
  };

  package_merge_depth_counter i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int eff_limit();
    return (sym_limit > MAX_SYMBOLS) ? MAX_SYMBOLS : sym_limit;
  endfunction

  function automatic int next_slot();
    return (leaf_cnt == '1) ? int'(leaf_cnt) : int'(leaf_cnt) + 1;
  endfunction

  function automatic bit track_depths(in_item_t it, output out_item_t res);
    int slot;
    res = '0;
    case (it.command)
      CMD_LOAD: begin
        sym_freq[it.symbol_index] = it.item_value;
        sym_depth[it.symbol_index] = '0;
      end
      CMD_NODE: begin
        if (!it.is_package) begin
          if (leaf_cnt != '1) leaf_cnt++;
          slot = int'(leaf_cnt);
          if (slot >= 1 && slot <= eff_limit() && sym_freq.exists(slot - 1) &&
              sym_freq[slot - 1] == it.item_value && sym_depth[slot - 1] < MAX_LEVELS)
            sym_depth[slot - 1]++;
        end
        if (it.last_in_level) leaf_cnt = '0;
      end
      CMD_READ: begin
        res.depth_symbol = it.symbol_index;
        res.code_length = sym_depth.exists(it.symbol_index) ? sym_depth[it.symbol_index] : '0;
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic in_item_t scramble(cmd_t c);
    in_item_t it;
    it.command       = c;
    it.symbol_index  = SYM_W'($urandom);
    it.item_value    = $urandom;
    it.is_package    = 1'($urandom);
    it.last_in_level = 1'($urandom);
    return it;
  endfunction

  function automatic logic [VAL_W-1:0] pool_value();
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      2: return VAL_W'($urandom_range(1, 7));
      default: return $urandom;
    endcase
  endfunction

  task automatic transfer(in_item_t it, bit typed, out_item_t given);
    out_item_t got;
    @(negedge clk);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (track_depths(it, got)) pending_lengths.push_back(typed ? given : got);
    sent++;
  endtask

  task automatic load_symbol(int idx, logic [VAL_W-1:0] v);
    in_item_t it;
    it = scramble(CMD_LOAD);
    it.symbol_index = SYM_W'(idx);
    it.item_value = v;
    transfer(it, 1'b0, '0);
  endtask

  task automatic read_symbol(int idx);
    in_item_t it;
    if (!sym_freq.exists(idx)) load_symbol(idx, pool_value());
    it = scramble(CMD_READ);
    it.symbol_index = SYM_W'(idx);
    transfer(it, 1'b0, '0);
  endtask

  task automatic node(bit as_package, bit closes, logic [VAL_W-1:0] v, bit hit);
    in_item_t it;
    int slot;
    slot = next_slot();
    // a leaf may only be compared against a loaded frequency
    if (!as_package && slot <= eff_limit() && !sym_freq.exists(slot - 1))
      load_symbol(slot - 1, pool_value());
    it = scramble(CMD_NODE);
    it.is_package = as_package;
    it.last_in_level = closes;
    it.item_value = (hit && sym_freq.exists(slot - 1)) ? sym_freq[slot - 1] : v;
    transfer(it, 1'b0, '0);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_lengths.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_symbol_count(logic [CNT_W-1:0] v);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    sym_limit = int'(v);
  endtask

  task automatic set_idling(idle_mode_t m);
    send_idle_pct = (m == IDLE_SEND) ? 65 : (m == IDLE_BOTH) ? 37 : 0;
    stall_pct     = (m == IDLE_STALL) ? 65 : (m == IDLE_BOTH) ? 37 : 0;
  endtask

  task automatic random_segment(int n);
    int start, r, len, lim;
    start = sent;
    while (sent - start < n) begin
      r = $urandom_range(99);
      lim = eff_limit();
      if (r < 75) begin
        // well-formed level, sometimes left open
        len = $urandom_range(1, (lim <= 2) ? 3 : 12);
        for (int k = 0; k < len; k++)
          node($urandom_range(99) < 25, (k == len - 1) && ($urandom_range(9) != 0),
               $urandom, $urandom_range(99) < 75);
        if ($urandom_range(99) < 50)
          read_symbol($urandom_range((lim > 0 && lim < 48) ? lim - 1 : 47));
      end else if (r < 81) begin
        load_symbol($urandom_range(MAX_SYMBOLS - 1), pool_value());
      end else if (r < 88) begin
        read_symbol($urandom_range(MAX_SYMBOLS - 1));
      end else if (r < 94) begin
        transfer(scramble(CMD_UNUSED), 1'b0, '0);
      end else begin
        read_symbol($urandom_range((lim > 0 && lim < 16) ? lim - 1 : 15));
      end
    end
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      checked++;
      if (pending_lengths.size() == 0) begin
        mismatches++;
        $display("%0t: expected no transaction, got symbol %0d length %0d",
                 $time, out_data.depth_symbol, out_data.code_length);
      end else begin
        want = pending_lengths.pop_front();
        if (out_data.depth_symbol !== want.depth_symbol) begin
          mismatches++;
          $display("%0t: depth_symbol expected %0d actual %0d",
                   $time, want.depth_symbol, out_data.depth_symbol);
        end
        if (out_data.code_length !== want.code_length) begin
          mismatches++;
          $display("%0t: code_length of symbol %0d expected %0d actual %0d",
                   $time, want.depth_symbol, want.code_length, out_data.code_length);
        end
      end
    end
  end

  initial begin
    logic [CNT_W-1:0] counts [8];
    counts = '{CNT_W'(0), CNT_W'(1), CNT_W'(2), CNT_W'(5), CNT_W'($urandom_range(6, 40)),
               CNT_W'(MAX_SYMBOLS), '1, CNT_W'($urandom)};

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    set_idling(IDLE_NONE);
    write_symbol_count(CNT_W'(3));
    foreach (directed[i]) transfer(directed[i].item, directed[i].typed, directed[i].res);
    drain();

    for (int k = 0; k < 8; k++) begin
      write_symbol_count(counts[k]);
      set_idling(idle_mode_t'(k % 4));
      random_segment(SEGMENT_ITEMS);
      drain();
    end

    $display("%0d transactions sent, %0d depth reports checked", sent, checked);
    $display("symbol counts 0 to all-ones, open and closed levels, idle and stall mixes");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("run timed out at %0t", $time);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
